@@ hdl/gsm_pkg.sv @@
// ----------------------------------------------------------------------------
// gsm_pkg
// Shared types and codes of the generational slot map: operation and status
// codes, and the field write enables of the slot memory.
// ----------------------------------------------------------------------------
package gsm_pkg;

   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_STALE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   // field write enables of one slot memory write
   typedef struct packed {
      logic link_en;   // live flag and link
      logic gen_en;    // generation
   } slot_wr_ctl_type;

endpackage

@@ hdl/gsm_slot_mem.sv @@
// ----------------------------------------------------------------------------
// gsm_slot_mem
// Per-slot memory: live flag with link (dense position or next free slot)
// and generation, one write port with field enables, one registered read.
// ----------------------------------------------------------------------------
module gsm_slot_mem
   import gsm_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int LINK_BITS = 5,
   parameter int GEN_BITS  = 16
) (
   input  logic                 clock,
   input  slot_wr_ctl_type      wr_ctl,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic                 wr_live,
   input  logic [LINK_BITS-1:0] wr_link,
   input  logic [GEN_BITS-1:0]  wr_gen,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic                 rd_live,
   output logic [LINK_BITS-1:0] rd_link,
   output logic [GEN_BITS-1:0]  rd_gen
);

   logic [LINK_BITS:0]   link_mem [DEPTH];
   logic [GEN_BITS-1:0]  gen_mem  [DEPTH];
   logic [LINK_BITS:0]   rd_link_ff;
   logic [GEN_BITS-1:0]  rd_gen_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.link_en) begin
         link_mem[wr_addr] <= {wr_live, wr_link};
      end
      if (wr_ctl.gen_en) begin
         gen_mem[wr_addr] <= wr_gen;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_link_ff <= link_mem[rd_addr];
         rd_gen_ff  <= gen_mem[rd_addr];
      end
   end

   assign rd_live = rd_link_ff[LINK_BITS];
   assign rd_link = rd_link_ff[LINK_BITS-1:0];
   assign rd_gen  = rd_gen_ff;

endmodule

@@ hdl/gsm_dense_mem.sv @@
// ----------------------------------------------------------------------------
// gsm_dense_mem
// Dense value store with the owning slot of each entry, one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module gsm_dense_mem
   import gsm_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int ADDR_BITS  = 4,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [VALUE_BITS-1:0] wr_value,
   input  logic [ADDR_BITS-1:0]  wr_owner,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [VALUE_BITS-1:0] rd_value,
   output logic [ADDR_BITS-1:0]  rd_owner
);

   logic [VALUE_BITS+ADDR_BITS-1:0] entry_mem [DEPTH];
   logic [VALUE_BITS+ADDR_BITS-1:0] rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= {wr_value, wr_owner};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_value = rd_entry_ff[VALUE_BITS+ADDR_BITS-1:ADDR_BITS];
   assign rd_owner = rd_entry_ff[ADDR_BITS-1:0];

endmodule

@@ hdl/generational_slot_map.sv @@
// ----------------------------------------------------------------------------
// generational_slot_map
// Slot map with generational keys: insert, erase and lookup over a dense
// value store, a per-slot memory and a free list.
// ----------------------------------------------------------------------------
// Each request word is one operation and gives exactly one response word.
// Insert takes the head of the free list, appends the value to the dense
// store and returns the key (slot, generation); lookup returns the value of a
// live key with matching generation; erase bumps the generation, moves the
// last dense entry into the hole and frees the slot. Words are handled one at
// a time: insert, a miss and an erase of the last dense entry respond from
// ST_EXEC, while a lookup hit and an erase that moves an entry go on to
// ST_FETCH or ST_MOVE, as the slot and dense memories each have a single
// read port (slot read, then a dependent dense read or a second slot write).
// A new request is taken while the previous response still waits. After reset
// the block clears each slot of the slot memory before the first request.
module generational_slot_map
   import gsm_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   parameter int GEN_BITS   = 16,
   localparam int IDX_BITS  = $clog2(CAPACITY),
   localparam int LINK_BITS = $clog2(CAPACITY + 1),
   localparam int REQ_USED  = OP_BITS + IDX_BITS + GEN_BITS + VALUE_BITS,
   localparam int REQ_BITS  = ((REQ_USED + 7) / 8) * 8,
   localparam int RSP_USED  = STATUS_BITS + IDX_BITS + GEN_BITS + VALUE_BITS + LINK_BITS,
   localparam int RSP_BITS  = ((RSP_USED + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // operation, key_index, key_generation, item_value
   input  logic [REQ_BITS-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // status, new_key_index, new_key_generation, found_value, live_count
   output logic [RSP_BITS-1:0] rsp_tdata
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_MOVE  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_BITS-1:0]    clear_idx_ff, clear_idx_in;
   logic [LINK_BITS-1:0]   free_head_ff, free_head_in;
   logic [LINK_BITS-1:0]   count_ff, count_in;

   logic [OP_BITS-1:0]     op_ff, op_in;
   logic [IDX_BITS-1:0]    key_index_ff, key_index_in;
   logic [GEN_BITS-1:0]    key_gen_ff, key_gen_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_BITS-1:0]    rsp_index_ff, rsp_index_in;
   logic [GEN_BITS-1:0]    rsp_gen_ff, rsp_gen_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [LINK_BITS-1:0]   rsp_count_ff, rsp_count_in;

   logic [OP_BITS-1:0]     req_op;
   logic [IDX_BITS-1:0]    req_key_index;
   logic [GEN_BITS-1:0]    req_key_gen;
   logic [VALUE_BITS-1:0]  req_value;

   slot_wr_ctl_type        slot_wr_ctl;
   logic [IDX_BITS-1:0]    slot_wr_addr;
   logic                   slot_wr_live;
   logic [LINK_BITS-1:0]   slot_wr_link;
   logic [GEN_BITS-1:0]    slot_wr_gen;
   logic                   slot_rd_en;
   logic [IDX_BITS-1:0]    slot_rd_addr;
   logic                   slot_rd_live;
   logic [LINK_BITS-1:0]   slot_rd_link;
   logic [GEN_BITS-1:0]    slot_rd_gen;

   logic                   dense_wr_en;
   logic [IDX_BITS-1:0]    dense_wr_addr;
   logic [VALUE_BITS-1:0]  dense_wr_value;
   logic [IDX_BITS-1:0]    dense_wr_owner;
   logic                   dense_rd_en;
   logic [IDX_BITS-1:0]    dense_rd_addr;
   logic [VALUE_BITS-1:0]  dense_rd_value;
   logic [IDX_BITS-1:0]    dense_rd_owner;

   logic                   req_accept;
   logic                   out_free;
   logic                   key_match;
   logic [LINK_BITS-1:0]   last_pos;

   assign req_op        = req_tdata[OP_BITS-1:0];
   assign req_key_index = req_tdata[OP_BITS +: IDX_BITS];
   assign req_key_gen   = req_tdata[OP_BITS+IDX_BITS +: GEN_BITS];
   assign req_value     = req_tdata[OP_BITS+IDX_BITS+GEN_BITS +: VALUE_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_pos   = count_ff - LINK_BITS'(1);

   assign key_match = (LINK_BITS'(key_index_ff) < LINK_BITS'(CAPACITY))
                      && slot_rd_live && (slot_rd_gen == key_gen_ff);

   always_comb begin
      state_in       = state_ff;
      clear_idx_in   = clear_idx_ff;
      free_head_in   = free_head_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      key_index_in   = key_index_ff;
      key_gen_in     = key_gen_ff;
      value_in       = value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_gen_in     = rsp_gen_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_count_in   = rsp_count_ff;

      slot_wr_ctl    = '0;
      slot_wr_addr   = key_index_ff;
      slot_wr_live   = 1'b0;
      slot_wr_link   = free_head_ff;
      slot_wr_gen    = slot_rd_gen + GEN_BITS'(1);
      slot_rd_en     = 1'b0;
      slot_rd_addr   = req_key_index;
      dense_wr_en    = 1'b0;
      dense_wr_addr  = slot_rd_link[IDX_BITS-1:0];
      dense_wr_value = dense_rd_value;
      dense_wr_owner = dense_rd_owner;
      dense_rd_en    = 1'b0;
      dense_rd_addr  = last_pos[IDX_BITS-1:0];

      case (state_ff)
         ST_CLEAR: begin
            slot_wr_ctl.link_en = 1'b1;
            slot_wr_ctl.gen_en  = 1'b1;
            slot_wr_addr        = clear_idx_ff;
            slot_wr_live        = 1'b0;
            slot_wr_link        = LINK_BITS'(clear_idx_ff) + LINK_BITS'(1);
            slot_wr_gen         = '0;
            clear_idx_in        = clear_idx_ff + IDX_BITS'(1);
            if (LINK_BITS'(clear_idx_ff) == LINK_BITS'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in        = req_op;
               key_index_in = req_key_index;
               key_gen_in   = req_key_gen;
               value_in     = req_value;
               slot_rd_en   = 1'b1;
               slot_rd_addr = (req_op == OP_INSERT) ? free_head_ff[IDX_BITS-1:0]
                                                    : req_key_index;
               dense_rd_en  = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_status_in = STATUS_STALE;
               rsp_index_in  = '0;
               rsp_gen_in    = '0;
               rsp_value_in  = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
               case (op_ff)
                  OP_INSERT: begin
                     if (count_ff == LINK_BITS'(CAPACITY)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        slot_wr_ctl.link_en = 1'b1;
                        slot_wr_addr        = free_head_ff[IDX_BITS-1:0];
                        slot_wr_live        = 1'b1;
                        slot_wr_link        = count_ff;
                        dense_wr_en         = 1'b1;
                        dense_wr_addr       = count_ff[IDX_BITS-1:0];
                        dense_wr_value      = value_ff;
                        dense_wr_owner      = free_head_ff[IDX_BITS-1:0];
                        free_head_in        = slot_rd_link;
                        count_in            = count_ff + LINK_BITS'(1);
                        rsp_status_in       = STATUS_OK;
                        rsp_index_in        = free_head_ff[IDX_BITS-1:0];
                        rsp_gen_in          = slot_rd_gen;
                     end
                  end
                  OP_ERASE: begin
                     if (key_match) begin
                        slot_wr_ctl.link_en = 1'b1;
                        slot_wr_ctl.gen_en  = 1'b1;
                        slot_wr_live        = 1'b0;
                        free_head_in        = LINK_BITS'(key_index_ff);
                        count_in            = last_pos;
                        rsp_status_in       = STATUS_OK;
                        if (slot_rd_link != last_pos) begin
                           dense_wr_en  = 1'b1;
                           rsp_valid_in = rsp_valid_ff && !rsp_tready;
                           state_in     = ST_MOVE;
                        end
                     end
                  end
                  OP_LOOKUP: begin
                     if (key_match) begin
                        dense_rd_en   = 1'b1;
                        dense_rd_addr = slot_rd_link[IDX_BITS-1:0];
                        rsp_valid_in  = rsp_valid_ff && !rsp_tready;
                        state_in      = ST_FETCH;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_STALE;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         ST_FETCH: begin
            if (out_free) begin
               rsp_status_in = STATUS_OK;
               rsp_value_in  = dense_rd_value;
               rsp_count_in  = count_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_MOVE: begin
            if (out_free) begin
               slot_wr_ctl.link_en = 1'b1;
               slot_wr_addr        = dense_rd_owner;
               slot_wr_live        = 1'b1;
               slot_wr_link        = slot_rd_link;
               rsp_count_in        = count_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         free_head_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_index_ff  <= key_index_in;
      key_gen_ff    <= key_gen_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   gsm_slot_mem #(
      .DEPTH     (CAPACITY),
      .ADDR_BITS (IDX_BITS),
      .LINK_BITS (LINK_BITS),
      .GEN_BITS  (GEN_BITS)
   ) u_slot_mem (
      .clock   (clock),
      .wr_ctl  (slot_wr_ctl),
      .wr_addr (slot_wr_addr),
      .wr_live (slot_wr_live),
      .wr_link (slot_wr_link),
      .wr_gen  (slot_wr_gen),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_live (slot_rd_live),
      .rd_link (slot_rd_link),
      .rd_gen  (slot_rd_gen)
   );

   gsm_dense_mem #(
      .DEPTH      (CAPACITY),
      .ADDR_BITS  (IDX_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dense_mem (
      .clock    (clock),
      .wr_en    (dense_wr_en),
      .wr_addr  (dense_wr_addr),
      .wr_value (dense_wr_value),
      .wr_owner (dense_wr_owner),
      .rd_en    (dense_rd_en),
      .rd_addr  (dense_rd_addr),
      .rd_value (dense_rd_value),
      .rd_owner (dense_rd_owner)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_count_ff, rsp_value_ff, rsp_gen_ff,
                                  rsp_index_ff, rsp_status_ff});

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LINK_BITS'(CAPACITY))
      else $error("stored count above capacity");

   a_free_list_empty_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |->
         ((free_head_ff == LINK_BITS'(CAPACITY)) == (count_ff == LINK_BITS'(CAPACITY))))
      else $error("free list and stored count disagree");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EXEC))
      else $error("accepted word not executed");

   a_full_reports_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FULL)) |->
         (rsp_count_ff == LINK_BITS'(CAPACITY)))
      else $error("full status below capacity");

endmodule
